// File: rtl/alldiff_bounds_propagator_macros.svh
// Assertion shorthands used by the engine RTL
`ifndef ALLDIFF_BOUNDS_PROPAGATOR_MACROS_SVH
`define ALLDIFF_BOUNDS_PROPAGATOR_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ALDP_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define ALDP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/aldp_pkg.sv
package aldp_pkg;

	localparam int DEF_MAX_VARS    = 32;
	localparam int DEF_VALUE_WIDTH = 16;
	localparam int OUT_VALUE_W     = 16;
	localparam int OUT_INDEX_W     = 5;
	// wide enough for a count of up to 64 variables
	localparam int JOB_CNT_W       = 7;

	// one loaded set, handed from the loader to the engine
	typedef struct packed {
		logic [JOB_CNT_W-1:0] n;
		logic                 bad;
	} job_t;

endpackage

// File: rtl/alldiff_bounds_propagator.sv
// Bounds filter for an all-different constraint. Intervals [var_min, var_max] are
// transferred one per item into a record memory until the item with last_var set;
// items past MAX_VARS are dropped but their last mark still closes the set. The
// engine then sorts by ascending max, raises lower bounds past saturated Hall
// intervals, sorts by descending min, lowers upper bounds, marks singleton groups
// and returns one result per variable in arrival order, or a single result with
// failed set. Every compare step is a read state then an execute state on the single
// read port of the record memory. The loader takes no item while a closed set
// waits or runs in the engine or the job queue is full; a new set is taken once
// the previous run has handed over its last result to the output register.
module alldiff_bounds_propagator #(
	parameter int MAX_VARS    = aldp_pkg::DEF_MAX_VARS,
	parameter int VALUE_WIDTH = aldp_pkg::DEF_VALUE_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [VALUE_WIDTH-1:0]           var_min,
	input  logic [VALUE_WIDTH-1:0]           var_max,
	input  logic                             last_var,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [aldp_pkg::OUT_INDEX_W-1:0] var_index,
	output logic [aldp_pkg::OUT_VALUE_W-1:0] new_min,
	output logic [aldp_pkg::OUT_VALUE_W-1:0] new_max,
	output logic                             drop_var,
	output logic                             failed,
	output logic                             last_result
);

	import aldp_pkg::*;

	localparam int IW = $clog2(MAX_VARS);
	localparam int RW = IW + 2 * VALUE_WIDTH;

	job_t          job_in;
	job_t          job_out;
	logic          job_push;
	logic          job_full;
	logic          job_pop;
	logic          job_valid;
	logic          done;
	logic          f_we;
	logic [IW-1:0] f_waddr;
	logic [RW-1:0] f_wdata;
	logic          e_we;
	logic [IW-1:0] e_waddr;
	logic [RW-1:0] e_wdata;
	logic          rec_re;
	logic [IW-1:0] rec_raddr;
	logic [RW-1:0] rec_rdata;
	logic          rec_we;
	logic [IW-1:0] rec_waddr;
	logic [RW-1:0] rec_wdata;

	aldp_front #(.MAX_VARS(MAX_VARS), .VALUE_WIDTH(VALUE_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.var_min   (var_min),
		.var_max   (var_max),
		.last_var  (last_var),
		.rec_we    (f_we),
		.rec_waddr (f_waddr),
		.rec_wdata (f_wdata),
		.job       (job_in),
		.job_push  (job_push),
		.job_full  (job_full),
		.done      (done)
	);

	aldp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job_in),
		.full      (job_full),
		.pop       (job_pop),
		.pop_data  (job_out),
		.not_empty (job_valid)
	);

	// loader and engine never write the record store at the same time
	assign rec_we    = f_we | e_we;
	assign rec_waddr = f_we ? f_waddr : e_waddr;
	assign rec_wdata = f_we ? f_wdata : e_wdata;

	aldp_ram #(.WIDTH(RW), .DEPTH(MAX_VARS)) u_record_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (rec_waddr),
		.wdata (rec_wdata),
		.re    (rec_re),
		.raddr (rec_raddr),
		.rdata (rec_rdata)
	);

	aldp_engine #(.MAX_VARS(MAX_VARS), .VALUE_WIDTH(VALUE_WIDTH)) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.job         (job_out),
		.job_valid   (job_valid),
		.job_pop     (job_pop),
		.done        (done),
		.rec_re      (rec_re),
		.rec_raddr   (rec_raddr),
		.rec_rdata   (rec_rdata),
		.rec_we      (e_we),
		.rec_waddr   (e_waddr),
		.rec_wdata   (e_wdata),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.var_index   (var_index),
		.new_min     (new_min),
		.new_max     (new_max),
		.drop_var    (drop_var),
		.failed      (failed),
		.last_result (last_result)
	);

endmodule

// File: rtl/aldp_ram.sv
module aldp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, held while idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/aldp_fifo.sv
module aldp_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  aldp_pkg::job_t push_data,
	output logic           full,
	input  logic           pop,
	output aldp_pkg::job_t pop_data,
	output logic           not_empty
);

	import aldp_pkg::*;

	job_t       slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign pop_data  = slot_q[rp_q];

	// store the transferred descriptor
	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wp_q] <= push_data;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wp_q <= ~wp_q;
			end
			if (pop && not_empty) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'((push && !full) ? 1 : 0) - 2'((pop && not_empty) ? 1 : 0);
		end
	end

endmodule

// File: rtl/aldp_front.sv
module aldp_front #(
	parameter int MAX_VARS    = aldp_pkg::DEF_MAX_VARS,
	parameter int VALUE_WIDTH = aldp_pkg::DEF_VALUE_WIDTH
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_valid,
	output logic                                       in_ready,
	input  logic [VALUE_WIDTH-1:0]                     var_min,
	input  logic [VALUE_WIDTH-1:0]                     var_max,
	input  logic                                       last_var,
	output logic                                       rec_we,
	output logic [$clog2(MAX_VARS)-1:0]                rec_waddr,
	output logic [$clog2(MAX_VARS)+2*VALUE_WIDTH-1:0]  rec_wdata,
	output aldp_pkg::job_t                             job,
	output logic                                       job_push,
	input  logic                                       job_full,
	input  logic                                       done
);

	import aldp_pkg::*;

	localparam int IW = $clog2(MAX_VARS);
	localparam int CW = $clog2(MAX_VARS + 1);

	logic [CW-1:0] cnt_q;
	logic          bad_q;
	logic          lock_q;
	logic          accept;
	logic          room;
	logic [CW-1:0] cnt_n;
	logic          bad_n;

	assign in_ready = !lock_q && !job_full;
	assign accept   = in_valid && in_ready;

	// classify the item: store it if there is room, flag an empty interval
	assign room  = (cnt_q < CW'(MAX_VARS));
	assign cnt_n = room ? cnt_q + CW'(1) : cnt_q;
	assign bad_n = bad_q | (room && (var_max < var_min));

	assign rec_we    = accept && room;
	assign rec_waddr = cnt_q[IW-1:0];
	assign rec_wdata = {cnt_q[IW-1:0], var_min, var_max};

	// hand the closed set to the engine
	assign job_push = accept && last_var;
	assign job.n    = JOB_CNT_W'(cnt_n);
	assign job.bad  = bad_n;

	// count items; hold off new sets while the engine owns the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			bad_q  <= 1'b0;
			lock_q <= 1'b0;
		end else begin
			if (accept) begin
				if (last_var) begin
					cnt_q  <= '0;
					bad_q  <= 1'b0;
					lock_q <= 1'b1;
				end else begin
					cnt_q <= cnt_n;
					bad_q <= bad_n;
				end
			end
			if (done) begin
				lock_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/aldp_engine.sv
`include "alldiff_bounds_propagator_macros.svh"

module aldp_engine #(
	parameter int MAX_VARS    = aldp_pkg::DEF_MAX_VARS,
	parameter int VALUE_WIDTH = aldp_pkg::DEF_VALUE_WIDTH
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  aldp_pkg::job_t                            job,
	input  logic                                      job_valid,
	output logic                                      job_pop,
	output logic                                      done,
	output logic                                      rec_re,
	output logic [$clog2(MAX_VARS)-1:0]               rec_raddr,
	input  logic [$clog2(MAX_VARS)+2*VALUE_WIDTH-1:0] rec_rdata,
	output logic                                      rec_we,
	output logic [$clog2(MAX_VARS)-1:0]               rec_waddr,
	output logic [$clog2(MAX_VARS)+2*VALUE_WIDTH-1:0] rec_wdata,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic [aldp_pkg::OUT_INDEX_W-1:0]          var_index,
	output logic [aldp_pkg::OUT_VALUE_W-1:0]          new_min,
	output logic [aldp_pkg::OUT_VALUE_W-1:0]          new_max,
	output logic                                      drop_var,
	output logic                                      failed,
	output logic                                      last_result
);

	import aldp_pkg::*;

	localparam int IW = $clog2(MAX_VARS);
	localparam int CW = $clog2(MAX_VARS + 1);
	localparam int VW = VALUE_WIDTH;
	localparam int HW = VW + 2;
	localparam int OW = 2 * VW + 1;
	localparam logic signed [HW-1:0] HONE = HW'(1);

	typedef enum logic [20:0] {
		S_IDLE    = 21'd1,
		S_SRT_RI  = 21'd2,
		S_SRT_LI  = 21'd4,
		S_SRT_RJ  = 21'd8,
		S_SRT_CJ  = 21'd16,
		S_SRT_PUT = 21'd32,
		S_P_RI    = 21'd64,
		S_P_LI    = 21'd128,
		S_P_RJ    = 21'd256,
		S_P_EJ    = 21'd512,
		S_P_FIN   = 21'd1024,
		S_P_RK    = 21'd2048,
		S_P_EK    = 21'd4096,
		S_M_R0    = 21'd8192,
		S_M_L0    = 21'd16384,
		S_M_RI    = 21'd32768,
		S_M_EI    = 21'd65536,
		S_M_LAST  = 21'd131072,
		S_O_RD    = 21'd262144,
		S_O_LD    = 21'd524288,
		S_FAIL    = 21'd1048576
	} state_t;

	typedef struct packed {
		logic [IW-1:0] pos;
		logic [VW-1:0] lo;
		logic [VW-1:0] hi;
	} rec_t;

	function automatic logic signed [HW-1:0] sx(input logic [VW-1:0] x);
		return signed'({2'b00, x});
	endfunction

	state_t               state_q;
	logic                 out_valid_q;
	rec_t                 r;
	rec_t                 v_q;
	rec_t                 held_q;
	rec_t                 wrec;
	logic                 dir_q;
	logic [CW-1:0]        n_q;
	logic [CW-1:0]        i_q;
	logic [CW-1:0]        j_q;
	logic [CW-1:0]        k_q;
	logic [CW-1:0]        pre_q;
	logic [VW-1:0]        lo_i_q;
	logic [VW-1:0]        hi_i_q;
	logic [VW-1:0]        bmm_q;
	logic [VW-1:0]        reach_q;
	logic signed [HW-1:0] hc_i_q;
	logic signed [HW-1:0] b_q;
	logic                 have_q;

	logic                 hc_re;
	logic [IW-1:0]        hc_raddr;
	logic [HW-1:0]        hc_rdata;
	logic                 hc_we;
	logic [IW-1:0]        hc_waddr;
	logic [HW-1:0]        hc_wdata;
	logic                 o_re;
	logic [IW-1:0]        o_raddr;
	logic [OW-1:0]        o_rdata;
	logic                 o_we;
	logic [IW-1:0]        o_waddr;
	logic [OW-1:0]        o_wdata;

	logic signed [HW-1:0] hc_rd;
	logic signed [HW-1:0] t;
	logic signed [HW-1:0] bnd_i;
	logic                 before_v;
	logic                 hit;
	logic                 t_bad;
	logic                 t_eq;
	logic [VW-1:0]        key_j;
	logic                 better_j;
	logic                 f_bad;
	logic                 f_eq;
	logic [VW-1:0]        key_i;
	logic                 better_i;
	logic                 go_rk;
	logic                 k_in;
	logic                 k_bad;
	logic                 m_cut;
	logic                 drop_nx;
	logic                 i_wrap;
	logic [CW-1:0]        i_inc;
	logic                 last_o;
	logic                 can_load;
	logic [CW-1:0]        jm1;
	logic [CW-1:0]        nm1;
	state_t               pass_next;

	assign r     = rec_rdata;
	assign hc_rd = signed'(hc_rdata);
	assign i_inc = i_q + CW'(1);
	assign i_wrap = (i_inc == n_q);
	assign jm1   = j_q - CW'(1);
	assign nm1   = n_q - CW'(1);
	assign last_o   = i_wrap;
	assign can_load = !out_valid_q || out_ready;

	// sort key: ascending max for the first pass, descending min for the second
	assign before_v = dir_q ?
		((v_q.lo > r.lo) || ((v_q.lo == r.lo) && (v_q.pos < r.pos))) :
		((v_q.hi < r.hi) || ((v_q.hi == r.hi) && (v_q.pos < r.pos)));

	// Hall counter update against an earlier variable
	assign hit      = dir_q ? (r.hi > hi_i_q) : (r.lo < lo_i_q);
	assign t        = dir_q ? hc_rd - HONE : hc_rd + HONE;
	assign bnd_i    = dir_q ? sx(lo_i_q) : sx(hi_i_q);
	assign t_bad    = dir_q ? (t < bnd_i) : (t > bnd_i);
	assign t_eq     = (t == bnd_i);
	assign key_j    = dir_q ? r.hi : r.lo;
	assign better_j = !have_q || (dir_q ? (key_j > bmm_q) : (key_j < bmm_q));

	// own counter of the current variable
	assign f_bad    = dir_q ? (hc_i_q < bnd_i) : (hc_i_q > bnd_i);
	assign f_eq     = (hc_i_q == bnd_i);
	assign key_i    = dir_q ? hi_i_q : lo_i_q;
	assign better_i = !have_q || (dir_q ? (key_i > bmm_q) : (key_i < bmm_q));
	assign go_rk    = (have_q || f_eq) && (i_inc < n_q);

	// bound push onto a later variable
	assign k_in  = dir_q ? ((r.hi <= bmm_q) && (b_q < sx(r.hi))) :
		((r.lo >= bmm_q) && (b_q > sx(r.lo)));
	assign k_bad = dir_q ? (b_q < sx(r.lo)) : (b_q > sx(r.hi));

	// singleton group detection while walking down
	assign m_cut   = (r.lo > reach_q);
	assign drop_nx = m_cut && (pre_q == i_inc);

	assign pass_next = i_wrap ? (dir_q ? S_M_R0 : S_SRT_RI) : S_P_RI;

	assign job_pop = (state_q == S_IDLE) && job_valid;
	assign done    = ((state_q == S_O_LD) && can_load && last_o) ||
		((state_q == S_FAIL) && can_load);

	// record write data for a tightened bound
	always_comb begin
		wrec     = r;
		wrec.lo  = dir_q ? r.lo : b_q[VW-1:0];
		wrec.hi  = dir_q ? b_q[VW-1:0] : r.hi;
	end

	// drive memory ports from the sequencer state
	always_comb begin
		rec_re    = 1'b0;
		rec_raddr = i_q[IW-1:0];
		rec_we    = 1'b0;
		rec_waddr = j_q[IW-1:0];
		rec_wdata = v_q;
		hc_re     = 1'b0;
		hc_raddr  = j_q[IW-1:0];
		hc_we     = 1'b0;
		hc_waddr  = j_q[IW-1:0];
		hc_wdata  = t;
		o_re      = 1'b0;
		o_raddr   = i_q[IW-1:0];
		o_we      = 1'b0;
		o_waddr   = held_q.pos;
		o_wdata   = {held_q.lo, held_q.hi, drop_nx};
		case (state_q)
			S_SRT_RI, S_P_RI, S_M_RI: begin
				rec_re = 1'b1;
			end
			S_SRT_RJ: begin
				rec_re    = 1'b1;
				rec_raddr = jm1[IW-1:0];
			end
			S_SRT_CJ: begin
				rec_we    = 1'b1;
				rec_wdata = before_v ? r : v_q;
			end
			S_SRT_PUT: begin
				rec_we = 1'b1;
			end
			S_P_RJ: begin
				rec_re    = 1'b1;
				rec_raddr = j_q[IW-1:0];
				hc_re     = 1'b1;
			end
			S_P_EJ: begin
				hc_we = hit;
			end
			S_P_FIN: begin
				hc_we    = 1'b1;
				hc_waddr = i_q[IW-1:0];
				hc_wdata = hc_i_q;
			end
			S_P_RK: begin
				rec_re    = 1'b1;
				rec_raddr = k_q[IW-1:0];
			end
			S_P_EK: begin
				rec_we    = k_in && !k_bad;
				rec_waddr = k_q[IW-1:0];
				rec_wdata = wrec;
			end
			S_M_R0: begin
				rec_re    = 1'b1;
				rec_raddr = nm1[IW-1:0];
			end
			S_M_L0: begin
				o_we    = (n_q == CW'(1));
				o_waddr = r.pos;
				o_wdata = {r.lo, r.hi, 1'b0};
			end
			S_M_EI: begin
				o_we = 1'b1;
			end
			S_M_LAST: begin
				o_we    = 1'b1;
				o_wdata = {held_q.lo, held_q.hi, (pre_q == '0)};
			end
			S_O_RD: begin
				o_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	aldp_ram #(.WIDTH(HW), .DEPTH(MAX_VARS)) u_hall_ram (
		.clk   (clk),
		.we    (hc_we),
		.waddr (hc_waddr),
		.wdata (hc_wdata),
		.re    (hc_re),
		.raddr (hc_raddr),
		.rdata (hc_rdata)
	);

	aldp_ram #(.WIDTH(OW), .DEPTH(MAX_VARS)) u_result_ram (
		.clk   (clk),
		.we    (o_we),
		.waddr (o_waddr),
		.wdata (o_wdata),
		.re    (o_re),
		.raddr (o_raddr),
		.rdata (o_rdata)
	);

	// sequencer and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (((state_q == S_O_LD) || (state_q == S_FAIL)) && can_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						if (job.bad) begin
							state_q <= S_FAIL;
						end else if (job.n < JOB_CNT_W'(2)) begin
							state_q <= S_M_R0;
						end else begin
							state_q <= S_SRT_RI;
						end
					end
				end
				S_SRT_RI:  state_q <= S_SRT_LI;
				S_SRT_LI:  state_q <= S_SRT_RJ;
				S_SRT_RJ:  state_q <= S_SRT_CJ;
				S_SRT_CJ: begin
					if (before_v) begin
						state_q <= (j_q == CW'(1)) ? S_SRT_PUT : S_SRT_RJ;
					end else begin
						state_q <= i_wrap ? S_P_RI : S_SRT_RI;
					end
				end
				S_SRT_PUT: state_q <= i_wrap ? S_P_RI : S_SRT_RI;
				S_P_RI:    state_q <= S_P_LI;
				S_P_LI:    state_q <= (i_q == '0) ? S_P_FIN : S_P_RJ;
				S_P_RJ:    state_q <= S_P_EJ;
				S_P_EJ: begin
					if (hit && t_bad) begin
						state_q <= S_FAIL;
					end else begin
						state_q <= ((j_q + CW'(1)) == i_q) ? S_P_FIN : S_P_RJ;
					end
				end
				S_P_FIN: begin
					if (f_bad) begin
						state_q <= S_FAIL;
					end else begin
						state_q <= go_rk ? S_P_RK : pass_next;
					end
				end
				S_P_RK:    state_q <= S_P_EK;
				S_P_EK: begin
					if (k_in && k_bad) begin
						state_q <= S_FAIL;
					end else begin
						state_q <= ((k_q + CW'(1)) == n_q) ? pass_next : S_P_RK;
					end
				end
				S_M_R0:    state_q <= S_M_L0;
				S_M_L0:    state_q <= (n_q == CW'(1)) ? S_O_RD : S_M_RI;
				S_M_RI:    state_q <= S_M_EI;
				S_M_EI:    state_q <= (i_q == '0) ? S_M_LAST : S_M_RI;
				S_M_LAST:  state_q <= S_O_RD;
				S_O_RD:    state_q <= S_O_LD;
				S_O_LD: begin
					if (can_load) begin
						state_q <= last_o ? S_IDLE : S_O_RD;
					end
				end
				S_FAIL: begin
					if (can_load) begin
						state_q <= S_IDLE;
					end
				end
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	// working registers and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				n_q   <= job.n[CW-1:0];
				dir_q <= 1'b0;
				i_q   <= CW'(1);
			end
			S_SRT_LI: begin
				v_q <= r;
				j_q <= i_q;
			end
			S_SRT_CJ: begin
				if (before_v) begin
					j_q <= jm1;
				end else begin
					i_q <= i_wrap ? '0 : i_inc;
				end
			end
			S_SRT_PUT: begin
				i_q <= i_wrap ? '0 : i_inc;
			end
			S_P_LI: begin
				lo_i_q <= r.lo;
				hi_i_q <= r.hi;
				hc_i_q <= dir_q ? sx(r.hi) : sx(r.lo);
				have_q <= 1'b0;
				bmm_q  <= '0;
				j_q    <= '0;
			end
			S_P_EJ: begin
				if (hit) begin
					if (t_eq && better_j) begin
						bmm_q  <= key_j;
						have_q <= 1'b1;
					end
				end else begin
					hc_i_q <= dir_q ? hc_i_q - HONE : hc_i_q + HONE;
				end
				j_q <= j_q + CW'(1);
			end
			S_P_FIN: begin
				if (f_eq) begin
					have_q <= 1'b1;
					if (better_i) begin
						bmm_q <= key_i;
					end
				end
				b_q <= dir_q ? sx(lo_i_q) - HONE : sx(hi_i_q) + HONE;
				k_q <= i_inc;
				if (!go_rk) begin
					if (i_wrap) begin
						if (!dir_q) begin
							dir_q <= 1'b1;
							i_q   <= CW'(1);
						end
					end else begin
						i_q <= i_inc;
					end
				end
			end
			S_P_EK: begin
				k_q <= k_q + CW'(1);
				if ((k_q + CW'(1)) == n_q) begin
					if (i_wrap) begin
						if (!dir_q) begin
							dir_q <= 1'b1;
							i_q   <= CW'(1);
						end
					end else begin
						i_q <= i_inc;
					end
				end
			end
			S_M_L0: begin
				held_q  <= r;
				reach_q <= r.hi;
				pre_q   <= nm1;
				i_q     <= (n_q == CW'(1)) ? '0 : n_q - CW'(2);
			end
			S_M_EI: begin
				if (m_cut) begin
					pre_q   <= i_q;
					reach_q <= r.hi;
				end else if (r.hi > reach_q) begin
					reach_q <= r.hi;
				end
				held_q <= r;
				if (i_q != '0) begin
					i_q <= i_q - CW'(1);
				end
			end
			S_M_LAST: begin
				i_q <= '0;
			end
			S_O_LD: begin
				if (can_load) begin
					var_index   <= OUT_INDEX_W'(i_q);
					new_min     <= OUT_VALUE_W'(o_rdata[OW-1 -: VW]);
					new_max     <= OUT_VALUE_W'(o_rdata[VW:1]);
					drop_var    <= o_rdata[0];
					failed      <= 1'b0;
					last_result <= last_o;
					i_q         <= i_inc;
				end
			end
			S_FAIL: begin
				if (can_load) begin
					var_index   <= '0;
					new_min     <= '0;
					new_max     <= '0;
					drop_var    <= 1'b0;
					failed      <= 1'b1;
					last_result <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;

	`ALDP_ASSERT_IMPL(a_inner_below_outer, state_q == S_P_EJ, j_q < i_q, "inner index passed outer")
	`ALDP_ASSERT_IMPL(a_sweep_in_set, state_q == S_P_EK, k_q < n_q, "bound sweep left the set")
	`ALDP_ASSERT_NEXT(a_done_goes_idle, done, state_q == S_IDLE, "run ended without going idle")
	`ALDP_ASSERT_IMPL(a_result_in_set, state_q == S_O_LD, i_q < n_q, "result index beyond set")

endmodule
